// ===== hdl/dlxsc_pkg.sv =====
// Package for the dual shift-state word cipher: op codes, register indexes,
// the 256-word fill ROM and the one-step function of a 16-word state.
// No dependencies.
`default_nettype none
package dlxsc_pkg;
	localparam int KeyWords = 16;
	localparam int RomDepth = 256;
	localparam logic [15:0] FillMask = 16'h36c9;
	localparam logic [8:0] RoundBase = 9'd57;

	localparam logic [1:0] OP_INIT   = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic [1:0] REG_FUSE_LOW  = 2'd0;
	localparam logic [1:0] REG_FUSE_MID  = 2'd1;
	localparam logic [1:0] REG_FUSE_HIGH = 2'd2;
	localparam logic [1:0] REG_DECRYPT   = 2'd3;

	typedef logic [KeyWords-1:0][31:0] key_state_t;

	function automatic key_state_t step_state(input key_state_t o);
		key_state_t n;
		n[0]  = o[0] ^ o[13] ^ o[11] ^ o[7] ^ o[5] ^ o[3] ^ o[1];
		n[1]  = o[2];
		n[2]  = o[3] ^ o[2];
		n[3]  = o[4];
		n[4]  = o[5];
		n[5]  = o[6];
		n[6]  = o[7];
		n[7]  = o[7] ^ o[8];
		n[8]  = o[9];
		n[9]  = o[10];
		n[10] = {o[11][0], o[11][31:1]};
		n[11] = o[11] ^ o[12];
		n[12] = o[13];
		n[13] = o[14];
		n[14] = o[15];
		n[15] = o[0];
		return n;
	endfunction

	localparam logic [31:0] RomTable [RomDepth] = '{
		32'h6B8B4567,32'h327B23C6,32'h643C9869,32'h66334873,32'h74B0DC51,32'h19495CFF,
		32'h2AE8944A,32'h625558EC,32'h238E1F29,32'h46E87CCD,32'h3D1B58BA,32'h507ED7AB,
		32'h2EB141F2,32'h41B71EFB,32'h79E2A9E3,32'h7545E146,32'h515F007C,32'h5BD062C2,
		32'h12200854,32'h4DB127F8,32'h0216231B,32'h1F16E9E8,32'h1190CDE7,32'h66EF438D,
		32'h140E0F76,32'h3352255A,32'h109CF92E,32'h0DED7263,32'h7FDCC233,32'h1BEFD79F,
		32'h41A7C4C9,32'h6B68079A,32'h4E6AFB66,32'h25E45D32,32'h519B500D,32'h431BD7B7,
		32'h3F2DBA31,32'h7C83E458,32'h257130A3,32'h62BBD95A,32'h436C6125,32'h628C895D,
		32'h333AB105,32'h721DA317,32'h2443A858,32'h2D1D5AE9,32'h6763845E,32'h75A2A8D4,
		32'h08EDBDAB,32'h79838CB2,32'h4353D0CD,32'h0B03E0C6,32'h189A769B,32'h54E49EB4,
		32'h71F32454,32'h2CA88611,32'h0836C40E,32'h02901D82,32'h3A95F874,32'h08138641,
		32'h1E7FF521,32'h7C3DBD3D,32'h737B8DDC,32'h6CEAF087,32'h22221A70,32'h4516DDE9,
		32'h3006C83E,32'h614FD4A1,32'h419AC241,32'h5577F8E1,32'h440BADFC,32'h05072367,
		32'h3804823E,32'h77465F01,32'h7724C67E,32'h5C482A97,32'h2463B9EA,32'h5E884ADC,
		32'h51EAD36B,32'h2D517796,32'h580BD78F,32'h153EA438,32'h3855585C,32'h70A64E2A,
		32'h6A2342EC,32'h2A487CB0,32'h1D4ED43B,32'h725A06FB,32'h2CD89A32,32'h57E4CCAF,
		32'h7A6D8D3C,32'h4B588F54,32'h542289EC,32'h6DE91B18,32'h38437FDB,32'h7644A45C,
		32'h32FFF902,32'h684A481A,32'h579478FE,32'h749ABB43,32'h3DC240FB,32'h1BA026FA,
		32'h79A1DEAA,32'h75C6C33A,32'h12E685FB,32'h70C6A529,32'h520EEDD1,32'h374A3FE6,
		32'h4F4EF005,32'h23F9C13C,32'h649BB77C,32'h275AC794,32'h39386575,32'h1CF10FD8,
		32'h180115BE,32'h235BA861,32'h47398C89,32'h354FE9F9,32'h15B5AF5C,32'h741226BB,
		32'h0D34B6A8,32'h10233C99,32'h3F6AB60F,32'h61574095,32'h7E0C57B1,32'h77AE35EB,
		32'h579BE4F1,32'h310C50B3,32'h5FF87E05,32'h2F305DEF,32'h25A70BF7,32'h1DBABF00,
		32'h4AD084E9,32'h1F48EAA1,32'h1381823A,32'h5DB70AE5,32'h100F8FCA,32'h6590700B,
		32'h15014ACB,32'h5F5E7FD0,32'h098A3148,32'h799D0247,32'h06B94764,32'h42C296BD,
		32'h168E121F,32'h1EBA5D23,32'h661E3F1E,32'h5DC79EA8,32'h540A471C,32'h7BD3EE7B,
		32'h51D9C564,32'h613EFDC5,32'h0BF72B14,32'h11447B73,32'h42963E5A,32'h0A0382C5,
		32'h08F2B15E,32'h1A32234B,32'h3B0FD379,32'h68EB2F63,32'h4962813B,32'h60B6DF70,
		32'h06A5EE64,32'h14330624,32'h7FFFCA11,32'h1A27709E,32'h71EA1109,32'h100F59DC,
		32'h7FB7E0AA,32'h06EB5BD4,32'h6F6DD9AC,32'h094211F2,32'h00885E1B,32'h76272110,
		32'h4C04A8AF,32'h1716703B,32'h14E17E33,32'h3222E7CD,32'h74DE0EE3,32'h68EBC550,
		32'h2DF6D648,32'h46B7D447,32'h4A2AC315,32'h39EE015C,32'h57FC4FBB,32'h0CC1016F,
		32'h43F18422,32'h60EF0119,32'h26F324BA,32'h7F01579B,32'h49DA307D,32'h7055A5F5,
		32'h5FB8370B,32'h50801EE1,32'h0488AC1A,32'h5FB8011C,32'h6AA78F7F,32'h7672BD23,
		32'h6FC75AF8,32'h6A5F7029,32'h7D5E18F8,32'h5F3534A4,32'h73A1821B,32'h7DE67713,
		32'h555C55B5,32'h3FA62ACA,32'h14FCE74E,32'h6A3DD3E8,32'h71C91298,32'h09DAF632,
		32'h53299938,32'h1FBFE8E0,32'h5092CA79,32'h1D545C4D,32'h59ADEA3D,32'h288F1A34,
		32'h2A155DBC,32'h1D9F6E5F,32'h097E1B4E,32'h51088277,32'h1CA0C5FA,32'h53584BCB,
		32'h415E286C,32'h7C58FD05,32'h23D86AAC,32'h45E6D486,32'h5C10FE21,32'h0E7FFA2B,
		32'h3C5991AA,32'h4BD8591A,32'h78DF6A55,32'h39B7AAA2,32'h2B0D8DBE,32'h6C80EC70,
		32'h379E21B5,32'h0069E373,32'h2C27173B,32'h4C9B0904,32'h6AA7B75C,32'h1DF029D3,
		32'h5675FF36,32'h3DD15094,32'h3DB012B3,32'h2708C9AF,32'h5B25ACE2,32'h175DFCF0,
		32'h4F97E3E4,32'h053B0A9E,32'h34FD6B4F,32'h5915FF32,32'h56438D15,32'h519E3149,
		32'h2C6E4AFD,32'h17A1B582,32'h4DF72E4E,32'h5046B5A9
	};
endpackage
`default_nettype wire

// ===== hdl/dual_lfsr_xor_stream_cipher_core.sv =====
// Top level of the dual shift-state word cipher: fuse registers, both key
// states, the fill and round sequencer and the output register.
// Depends on dlxsc_pkg.
//
// channel  direction  handshake        payload
// in       to core    in_valid/stall   op, data_word
// out      from core  out_valid/stall  result_word, is_check
// cfg      to core    cfg_valid/ready  cfg_index, cfg_data
//
// An init transaction fills the 16 words of both key states from the ROM, then
// one shared step unit advances the accumulator state for (round byte + 57)
// rounds, 57..312, then for as many rounds advances the pad state.
// The result of a data or finish transaction waits
// in the output register; the input stalls while that register is full or init
// is running. Reset clears all state and registers.
`default_nettype none
module dual_lfsr_xor_stream_cipher_core
	import dlxsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] data_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_word,
	output logic             is_check,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_PAD  = 2'd3;

	logic [31:0] fuse_low_q, fuse_mid_q, fuse_high_q;
	logic        decrypt_q;
	key_state_t  acc_q, pad_q;
	logic [31:0] cur_pad_q, last_acc_q;
	logic [1:0]  grp_q;
	logic [1:0]  state_q;
	logic [8:0]  cnt_q;
	logic [3:0]  fill_q;

	logic        in_acc;
	logic [7:0]  start;
	logic [8:0]  rounds;
	logic [31:0] seed;
	logic        shared_sel;
	key_state_t  step_in, step_out;
	logic [7:0]  rom_a, rom_p;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE) || out_valid;
	assign in_acc    = in_valid && !in_stall;
	assign start     = fuse_high_q[31:24] | fuse_high_q[23:16];
	assign rounds    = {1'b0, fuse_high_q[15:8] | fuse_high_q[7:0]} + RoundBase;
	assign seed      = fuse_low_q | fuse_mid_q;
	assign rom_a     = start + {4'd0, fill_q};
	assign rom_p     = start + 8'd16 + {4'd0, fill_q};

	// The shared step unit serves the pad state only during the pad rounds;
	// otherwise it steps the accumulator state.
	assign shared_sel = (state_q == ST_PAD);
	assign step_in    = shared_sel ? pad_q : acc_q;
	assign step_out   = step_state(step_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuse_low_q <= '0; fuse_mid_q <= '0; fuse_high_q <= '0; decrypt_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FUSE_LOW:  fuse_low_q  <= cfg_data;
				REG_FUSE_MID:  fuse_mid_q  <= cfg_data;
				REG_FUSE_HIGH: fuse_high_q <= cfg_data;
				REG_DECRYPT:   decrypt_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	key_state_t  pad_n;
	always_comb begin
		pad_n = step_state(pad_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; pad_q <= '0; cur_pad_q <= '0; last_acc_q <= '0;
			grp_q <= '0; state_q <= ST_IDLE; cnt_q <= '0; fill_q <= '0;
			out_valid <= 1'b0; result_word <= '0; is_check <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_FILL: begin
					// The seed goes into word zero even when the mask clears it.
					acc_q[fill_q] <= (FillMask[fill_q] ? 32'd0 : RomTable[rom_a]) ^
						((fill_q == 4'd0) ? seed : 32'd0);
					pad_q[fill_q] <= (FillMask[fill_q] ? 32'd0 : RomTable[rom_p]) ^
						((fill_q == 4'd0) ? seed : 32'd0);
					fill_q <= fill_q + 4'd1;
					if (fill_q == 4'(KeyWords - 1)) begin
						state_q <= ST_ACC;
						cnt_q   <= '0;
					end
				end
				ST_ACC: begin
					acc_q <= step_out;
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == rounds - 9'd1) begin
						state_q <= ST_PAD;
						cnt_q   <= '0;
					end
				end
				ST_PAD: begin
					pad_q <= step_out;
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == rounds - 9'd1)
						state_q <= ST_IDLE;
				end
				default: begin
					if (in_acc) begin
						case (op)
							OP_INIT: begin
								state_q <= ST_FILL; fill_q <= '0;
								cur_pad_q <= '0; last_acc_q <= '0; grp_q <= '0;
							end
							OP_DATA: begin : data_blk
								logic [31:0] p, r;
								key_state_t a;
								p = (grp_q == 2'd0) ? pad_n[0] : cur_pad_q;
								r = data_word ^ p;
								a = acc_q;
								a[0] = a[0] ^ (decrypt_q ? r : data_word);
								if (grp_q == 2'd0) begin
									pad_q <= pad_n;
									cur_pad_q <= pad_n[0];
								end
								if (grp_q == 2'd3) begin
									a = step_state(a);
									last_acc_q <= a[0];
								end
								acc_q <= a;
								grp_q <= grp_q + 2'd1;
								result_word <= r; is_check <= 1'b0; out_valid <= 1'b1;
							end
							OP_FINISH: begin
								if (grp_q != 2'd0) begin
									acc_q <= step_out;
									result_word <= step_out[0] ^ pad_n[0];
								end else
									result_word <= last_acc_q ^ pad_n[0];
								pad_q <= pad_n;
								grp_q <= '0; last_acc_q <= '0;
								is_check <= 1'b1; out_valid <= 1'b1;
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accepted while busy");
	a_result_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall)) else $error("spurious result");
	a_fill_to_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && fill_q == 4'(KeyWords - 1)) |=> (state_q == ST_ACC))
		else $error("fill did not hand over");
	a_group_clear_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_FINISH) |=> (grp_q == 2'd0 && is_check))
		else $error("finish left group open");
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the dual shift-state word cipher core.
// Depends on dlxsc_pkg and dual_lfsr_xor_stream_cipher_core; predicts every result
// in its own model of both key states and compares in order.
`default_nettype none
module tb;
	import dlxsc_pkg::*;

	// The fourth op value has no meaning and must be ignored by the core.
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [31:0] word;
		logic        check;
	} cipher_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_INIT;
	logic [31:0] data_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_word;
	logic        is_check;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_FUSE_LOW;
	logic [31:0] cfg_data = '0;

	dual_lfsr_xor_stream_cipher_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .data_word(data_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_word(result_word), .is_check(is_check),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the configuration and key states.
	logic [31:0] m_fuse_low, m_fuse_mid, m_fuse_high;
	logic        m_decrypt;
	logic [15:0][31:0] m_acc, m_pad;
	logic [31:0] m_cur_pad, m_last_acc;
	logic [1:0]  m_group;

	cipher_out_t expected_q[$];
	int   errors = 0;
	int   cycle = 0;
	bit   rx_stall_en = 1'b1;
	bit   tx_gap_en = 1'b1;
	int   hold_cycles = 0;

	function automatic logic [15:0][31:0] advance(input logic [15:0][31:0] o);
		logic [15:0][31:0] n;
		n[0] = o[0] ^ o[13] ^ o[11] ^ o[7] ^ o[5] ^ o[3] ^ o[1];
		n[1] = o[2];
		n[2] = o[3] ^ o[2];
		for (int i = 3; i <= 6; i++) n[i] = o[i+1];
		n[7] = o[7] ^ o[8];
		n[8] = o[9];
		n[9] = o[10];
		n[10] = {o[11][0], o[11][31:1]};
		n[11] = o[11] ^ o[12];
		n[12] = o[13];
		n[13] = o[14];
		n[14] = o[15];
		n[15] = o[0];
		return n;
	endfunction

	task automatic predict_keys_init();
		logic [7:0] start;
		int rounds;
		logic [31:0] seed;
		start = m_fuse_high[31:24] | m_fuse_high[23:16];
		rounds = int'(m_fuse_high[15:8] | m_fuse_high[7:0]) + 57;
		seed = m_fuse_low | m_fuse_mid;
		for (int i = 0; i < 16; i++) begin
			m_acc[i] = FillMask[i] ? 32'h0 : RomTable[8'(start + i)];
			m_pad[i] = FillMask[i] ? 32'h0 : RomTable[8'(start + 16 + i)];
		end
		m_acc[0] ^= seed;
		m_pad[0] ^= seed;
		for (int i = 0; i < rounds; i++) begin
			m_acc = advance(m_acc);
			m_pad = advance(m_pad);
		end
		m_cur_pad = '0;
		m_last_acc = '0;
		m_group = '0;
	endtask

	task automatic predict_cipher(input logic [1:0] code, input logic [31:0] word);
		cipher_out_t r;
		case (code)
			OP_INIT: predict_keys_init();
			OP_DATA: begin
				if (m_group == 0) begin
					m_pad = advance(m_pad);
					m_cur_pad = m_pad[0];
				end
				r.word = word ^ m_cur_pad;
				r.check = 1'b0;
				m_acc[0] ^= m_decrypt ? r.word : word;
				m_group = m_group + 2'd1;
				if (m_group == 0) begin
					m_acc = advance(m_acc);
					m_last_acc = m_acc[0];
				end
				expected_q.push_back(r);
			end
			OP_FINISH: begin
				if (m_group != 0) begin
					m_acc = advance(m_acc);
					m_last_acc = m_acc[0];
				end
				m_pad = advance(m_pad);
				r.word = m_last_acc ^ m_pad[0];
				r.check = 1'b1;
				m_group = '0;
				m_last_acc = '0;
				expected_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Receiver side: random stall bursts, plus an optional long hold-off.
	int stall_left = 0;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker.
	always @(posedge clk) begin
		cipher_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word %h check %b", $time,
					result_word, is_check);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result_word !== e.word) begin
					$display("%0t: result_word expected %h actual %h", $time,
						e.word, result_word);
					errors++;
				end
				if (is_check !== e.check) begin
					$display("%0t: is_check expected %b actual %b", $time,
						e.check, is_check);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle++;
		if (cycle > 2000000) begin
			$display("** dual_lfsr_xor_stream_cipher_core: FAILED **");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] code, input logic [31:0] word);
		int gap;
		if (tx_gap_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		data_word <= word;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_cipher(code, word);
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		// An init transaction may still be stepping the key states.
		repeat (700) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FUSE_LOW:  m_fuse_low = value;
			REG_FUSE_MID:  m_fuse_mid = value;
			REG_FUSE_HIGH: m_fuse_high = value;
			default:       m_decrypt = value[0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_fuses(input logic [31:0] lo, input logic [31:0] mid,
			input logic [31:0] hi, input logic dec);
		go_quiet();
		write_reg(REG_FUSE_LOW, lo);
		write_reg(REG_FUSE_MID, mid);
		write_reg(REG_FUSE_HIGH, hi);
		write_reg(REG_DECRYPT, {31'b0, dec});
	endtask

	// Data and finish straight out of reset, and the unused op value.
	task automatic test_before_init();
		send_item(OP_DATA, 32'h0);
		send_item(OP_DATA, 32'hFFFF_FFFF);
		send_item(OP_SPARE, 32'h1234_5678);
		send_item(OP_FINISH, 32'h0);
		send_item(OP_FINISH, 32'h0);
	endtask

	// Extreme fuse values, ROM index wrap, partial and full groups.
	task automatic test_directed();
		set_fuses(32'h0, 32'h0, 32'h0, 1'b0);
		send_item(OP_INIT, 32'h0);
		send_item(OP_FINISH, 32'h0);
		for (int i = 0; i < 5; i++) send_item(OP_DATA, i[0] ? 32'hFFFF_FFFF : 32'h0);
		send_item(OP_FINISH, 32'h0);
		set_fuses(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_INIT, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) send_item(OP_DATA, 32'h8000_0001 << i);
		send_item(OP_FINISH, 32'h0);
		set_fuses(32'h5555_5555, 32'hAAAA_AAAA, 32'hF800_0000, 1'b0);
		send_item(OP_INIT, 32'h0);
		send_item(OP_DATA, 32'hDEAD_BEEF);
		send_item(OP_SPARE, 32'h0);
		send_item(OP_FINISH, 32'h0);
	endtask

	task automatic random_message(input int words);
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(0, 30) == 0) send_item(OP_SPARE, $urandom);
			else send_item(OP_DATA, $urandom);
		end
		send_item(OP_FINISH, $urandom);
	endtask

	task automatic test_random(input int total);
		int sent;
		logic [31:0] hi;
		sent = 0;
		while (sent < total) begin
			// Mostly small round counts keep init short.
			hi = $urandom;
			if ($urandom_range(0, 3) != 0) hi[15:0] = 16'(1 << $urandom_range(0, 15));
			set_fuses($urandom, $urandom, hi, 1'($urandom_range(0, 1)));
			send_item(OP_INIT, $urandom);
			for (int m = 0; m < 4; m++) begin
				random_message($urandom_range(0, 20));
				sent += 11;
			end
			if ($urandom_range(0, 4) == 0) send_item(OP_INIT, $urandom);
		end
	endtask

	// The receiver holds off long enough for the input to back up.
	task automatic test_backpressure();
		hold_cycles = 60;
		random_message(30);
		// The sender then waits for every outstanding result.
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		random_message(12);
	endtask

	initial begin
		m_fuse_low = '0; m_fuse_mid = '0; m_fuse_high = '0; m_decrypt = 1'b0;
		m_acc = '0; m_pad = '0; m_cur_pad = '0; m_last_acc = '0; m_group = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_init();
		test_directed();
		test_random(1300);
		test_backpressure();
		go_quiet();
		rx_stall_en = 1'b0;
		tx_gap_en = 1'b0;
		test_random(150);
		go_quiet();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("** dual_lfsr_xor_stream_cipher_core: PASSED **");
		end else begin
			$display("** dual_lfsr_xor_stream_cipher_core: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire
